// File: sv/streamline_direction_color_macros.svh
// assertion helpers for the streamline colour block
`ifndef STREAMLINE_DIRECTION_COLOR_MACROS_SVH
`define STREAMLINE_DIRECTION_COLOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define SDC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/sdc_pkg.sv
package sdc_pkg;

	// coordinate and arithmetic widths
	localparam int COORD_WIDTH = 16;
	localparam int DIFF_W      = COORD_WIDTH + 1;
	localparam int MAG_W       = COORD_WIDTH;
	localparam int SQ_W        = 2 * COORD_WIDTH;
	localparam int SUM_W       = SQ_W + 2;
	localparam int CHAN_W      = 8;
	localparam int SCALE       = 65025;
	localparam int SCALE_W     = 16;
	localparam int RHS_W       = SQ_W + SCALE_W;
	localparam int VS_W        = SUM_W + CHAN_W;
	localparam int TSS_W       = SUM_W + 2 * CHAN_W;
	localparam int BIT_W       = 3;

	// stream widths
	localparam int PIN_W       = 3 * COORD_WIDTH;
	localparam int IN_TDATA_W  = ((PIN_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 3 * CHAN_W;

	typedef logic [COORD_WIDTH-1:0] coord_t;
	typedef coord_t [2:0] point_t;
	typedef logic [CHAN_W-1:0] chan_t;

	// controller states
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DIFF   = 6'b000010,
		ST_SQUARE = 6'b000100,
		ST_SCALE  = 6'b001000,
		ST_SEARCH = 6'b010000,
		ST_WRITE  = 6'b100000
	} sdc_state_t;

	// controller to datapath
	typedef struct packed {
		logic             load_in;
		logic             set_prev;
		logic             diff;
		logic             sel_older;
		logic             square;
		logic             scale;
		logic             search;
		logic [BIT_W-1:0] bit_idx;
		logic             write_out;
		logic             write_black;
		logic             eol;
		logic             shift_points;
	} sdc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_busy;
	} sdc_status_t;

endpackage

// File: sv/streamline_direction_color.sv
// a result is registered in the output register after the diff, square, scale, 8-step search
// and write sequence, and a final point gives a second colour after a second pass; a lone
// point gives a black result with no arithmetic, and a line's first point is only stored;
// the write waits while the output register is held, and a new point is taken only once
// the controller is idle again
// reset: arst_n clears the controller, line position and output valid at once
module streamline_direction_color (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// pos_x [15:0], pos_y [31:16], pos_z [47:32]
	input  logic [sdc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// red [7:0], green [15:8], blue [23:16]
	output logic [sdc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tlast
);

	sdc_pkg::sdc_cmd_t    cmd;
	sdc_pkg::sdc_status_t status;

	// sequencing
	sdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// arithmetic and output register
	sdc_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	`include "streamline_direction_color_macros.svh"

	`SDC_ASSERT_IMPL(a_no_overwrite, clk, arst_n, cmd.write_out || cmd.write_black, !status.out_busy, "result written over a pending one")
	`SDC_ASSERT_NEXT(a_last_blocks, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "final point did not start work")
	`SDC_ASSERT_IMPL(a_search_busy, clk, arst_n, cmd.search || cmd.diff, !s_axis_tready, "request taken while colour in progress")

endmodule

// File: sv/sdc_ctrl.sv
module sdc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_last,
	output logic                  in_ready,
	input  sdc_pkg::sdc_status_t  status,
	output sdc_pkg::sdc_cmd_t     cmd
);

	sdc_pkg::sdc_state_t         state_q;
	logic [1:0]                  seen_q;
	logic                        last_q;
	logic                        pass_q;
	logic                        black_q;
	logic [sdc_pkg::BIT_W-1:0]   bit_q;
	logic                        accept;

	assign in_ready = (state_q == sdc_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;

	// command decode
	always_comb begin
		cmd         = '0;
		cmd.bit_idx = bit_q;
		cmd.eol     = pass_q || black_q;
		case (state_q)
			sdc_pkg::ST_IDLE: begin
				cmd.load_in  = accept;
				cmd.set_prev = accept && (seen_q == 2'd0) && !in_last;
			end
			sdc_pkg::ST_DIFF: begin
				cmd.diff      = 1'b1;
				cmd.sel_older = !pass_q && (seen_q == 2'd2);
			end
			sdc_pkg::ST_SQUARE: cmd.square = 1'b1;
			sdc_pkg::ST_SCALE:  cmd.scale  = 1'b1;
			sdc_pkg::ST_SEARCH: cmd.search = 1'b1;
			sdc_pkg::ST_WRITE: begin
				if (!status.out_busy) begin
					cmd.write_black  = black_q;
					cmd.write_out    = !black_q;
					cmd.shift_points = !black_q && !last_q;
				end
			end
			default: ;
		endcase
	end

	// sequencing and line bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdc_pkg::ST_IDLE;
			seen_q  <= 2'd0;
			last_q  <= 1'b0;
			pass_q  <= 1'b0;
			black_q <= 1'b0;
			bit_q   <= '0;
		end else begin
			case (state_q)
				sdc_pkg::ST_IDLE: begin
					if (accept) begin
						last_q <= in_last;
						pass_q <= 1'b0;
						if (seen_q == 2'd0) begin
							if (in_last) begin
								black_q <= 1'b1;
								state_q <= sdc_pkg::ST_WRITE;
							end else begin
								seen_q <= 2'd1;
							end
						end else begin
							black_q <= 1'b0;
							state_q <= sdc_pkg::ST_DIFF;
						end
					end
				end
				sdc_pkg::ST_DIFF:   state_q <= sdc_pkg::ST_SQUARE;
				sdc_pkg::ST_SQUARE: state_q <= sdc_pkg::ST_SCALE;
				sdc_pkg::ST_SCALE: begin
					bit_q   <= '1;
					state_q <= sdc_pkg::ST_SEARCH;
				end
				sdc_pkg::ST_SEARCH: begin
					if (bit_q == '0) begin
						state_q <= sdc_pkg::ST_WRITE;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				sdc_pkg::ST_WRITE: begin
					if (!status.out_busy) begin
						if (black_q) begin
							seen_q  <= 2'd0;
							black_q <= 1'b0;
							state_q <= sdc_pkg::ST_IDLE;
						end else if (!pass_q && last_q) begin
							pass_q  <= 1'b1;
							state_q <= sdc_pkg::ST_DIFF;
						end else if (last_q) begin
							seen_q  <= 2'd0;
							state_q <= sdc_pkg::ST_IDLE;
						end else begin
							seen_q  <= 2'd2;
							state_q <= sdc_pkg::ST_IDLE;
						end
					end
				end
				default: state_q <= sdc_pkg::ST_IDLE;
			endcase
		end
	end

endmodule

// File: sv/sdc_dpath.sv
module sdc_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [sdc_pkg::IN_TDATA_W-1:0]      in_data,
	input  sdc_pkg::sdc_cmd_t                   cmd,
	output sdc_pkg::sdc_status_t                status,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sdc_pkg::OUT_TDATA_W-1:0]     out_data,
	output logic                                out_last
);

	sdc_pkg::point_t in_point;
	sdc_pkg::point_t cur_q, prev_q, older_q, base;

	logic signed [sdc_pkg::DIFF_W-1:0] diff   [3];
	logic        [sdc_pkg::DIFF_W-1:0] absd   [3];
	logic        [sdc_pkg::MAG_W-1:0]  mag_q  [3];
	logic        [sdc_pkg::SQ_W-1:0]   dd_q   [3];
	logic        [sdc_pkg::SUM_W-1:0]  sum_q;
	logic        [sdc_pkg::RHS_W-1:0]  rhs_q  [3];
	sdc_pkg::chan_t                    v_q    [3];
	logic        [sdc_pkg::VS_W-1:0]   vs_q   [3];
	logic        [sdc_pkg::TSS_W-1:0]  vss_q  [3];
	logic        [sdc_pkg::TSS_W-1:0]  cand   [3];
	logic                              take   [3];
	logic        [sdc_pkg::BIT_W:0]    sh_a, sh_b;
	logic                              sum_nz;

	logic [sdc_pkg::OUT_TDATA_W-1:0]   out_data_q;
	logic                              out_last_q;
	logic                              out_valid_q;

	assign in_point = sdc_pkg::point_t'(in_data[sdc_pkg::PIN_W-1:0]);
	assign base     = cmd.sel_older ? older_q : prev_q;

	// tangent components and their magnitudes
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			diff[c] = $signed({cur_q[c][sdc_pkg::COORD_WIDTH-1], cur_q[c]})
			        - $signed({base[c][sdc_pkg::COORD_WIDTH-1], base[c]});
			absd[c] = diff[c][sdc_pkg::DIFF_W-1] ? (-diff[c]) : diff[c];
		end
	end

	// one bit of the channel search: candidate t = v | 2^k,
	// t*t*S = v*v*S + v*S*2^(k+1) + S*2^(2k)
	assign sh_a   = {1'b0, cmd.bit_idx} + 1'b1;
	assign sh_b   = {cmd.bit_idx, 1'b0};
	assign sum_nz = |sum_q;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			cand[c] = vss_q[c]
			        + (sdc_pkg::TSS_W'(vs_q[c]) << sh_a)
			        + (sdc_pkg::TSS_W'(sum_q) << sh_b);
			take[c] = (cand[c] <= sdc_pkg::TSS_W'(rhs_q[c]));
		end
	end

	// point history
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cur_q <= in_point;
		end
		if (cmd.set_prev) begin
			prev_q <= in_point;
		end
		if (cmd.shift_points) begin
			older_q <= prev_q;
			prev_q  <= cur_q;
		end
	end

	// colour arithmetic
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			if (cmd.diff) begin
				mag_q[c] <= absd[c][sdc_pkg::MAG_W-1:0];
			end
			if (cmd.square) begin
				dd_q[c] <= mag_q[c] * mag_q[c];
			end
			if (cmd.scale) begin
				rhs_q[c] <= dd_q[c] * sdc_pkg::SCALE_W'(sdc_pkg::SCALE);
				v_q[c]   <= '0;
				vs_q[c]  <= '0;
				vss_q[c] <= '0;
			end
			if (cmd.search && take[c]) begin
				v_q[c]   <= v_q[c] | (sdc_pkg::CHAN_W'(1) << cmd.bit_idx);
				vss_q[c] <= cand[c];
				vs_q[c]  <= vs_q[c] + (sdc_pkg::VS_W'(sum_q) << cmd.bit_idx);
			end
		end
		if (cmd.scale) begin
			sum_q <= sdc_pkg::SUM_W'(dd_q[0]) + sdc_pkg::SUM_W'(dd_q[1])
			       + sdc_pkg::SUM_W'(dd_q[2]);
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.write_out) begin
			out_data_q <= sum_nz ? {v_q[2], v_q[1], v_q[0]} : '0;
			out_last_q <= cmd.eol;
		end else if (cmd.write_black) begin
			out_data_q <= '0;
			out_last_q <= cmd.eol;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.write_out || cmd.write_black) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_busy = out_valid_q && !out_ready;
	assign out_valid       = out_valid_q;
	assign out_data        = out_data_q;
	assign out_last        = out_last_q;

endmodule
